### design/tpd_pkg.sv
// Shared constants and types for the tablet packet decoder.
`default_nettype none

package tpd_pkg;

    // Packet lengths in bytes
    localparam logic [3:0] SHORT_LEN = 4'd7;
    localparam logic [3:0] TILT_LEN  = 4'd9;
    localparam int         PKT_DEPTH = 9;

    // Bit positions within received bytes
    localparam int START_BIT  = 7;
    localparam int PROX_BIT   = 6;
    localparam int STYLUS_BIT = 5;
    localparam int SIDE2_BIT  = 5;
    localparam int SIDE1_BIT  = 4;
    localparam int TIP_BIT    = 3;
    localparam int PRESS0_BIT = 2;
    localparam int PRESS_HI_N = 6;

    // Width of the packed event on the output tdata bus
    localparam int EVT_BUS_W = 64;

    // One collected packet byte, start flag stripped
    typedef logic [6:0] pkt_byte_t;

    // All collected bytes, entry 0 in the low bits
    typedef logic [PKT_DEPTH-1:0][6:0] pkt_t;

    // One decoded pen event, last field in the low bits
    typedef struct packed {
        logic signed [6:0] tilt_y;
        logic signed [6:0] tilt_x;
        logic              tip;
        logic              side_two;
        logic              side_one;
        logic              eraser;
        logic              is_puck;
        logic [7:0]        pressure;
        logic [15:0]       pos_y;
        logic [15:0]       pos_x;
        logic              in_range;
    } pen_event_t;

    localparam int EVT_W = $bits(pen_event_t);

endpackage

`default_nettype wire

### design/tablet_packet_decoder.sv
// Top level: serial pen tablet packet collector and event decoder.
//
//  channel   dir  signals                          content
//  s_*       in   s_tvalid s_tready s_tdata[7:0]   rx_byte
//  m_*       out  m_tvalid m_tready m_tdata[63:0]  one pen event per packet
//  cfg_*     in   cfg_wr_en cfg_wr_data            tilt_mode
//
//  One byte is taken per cycle while s_tready is high; a packet's event is
//  registered into the output register, or the skid slot if it is full.
//  Control state and output valid flags are cleared by rst_n. A stalled
//  output holds one event in the output register and one more in the skid
//  slot; s_tready drops only while the skid slot is occupied.
`default_nettype none

module tablet_packet_decoder
    import tpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // rx_byte [7:0]
    input  logic [7:0]  s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // in_range [0], pos_x [16:1], pos_y [32:17], pressure [40:33],
    // is_puck [41], eraser [42], side_one [43], side_two [44], tip [45],
    // tilt_x [52:46], tilt_y [59:53], zero [63:60]
    output logic [63:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    logic        tilt_mode_reg;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic        in_prox_reg;
    logic        in_prox_next;
    logic        eraser_reg;
    logic        eraser_next;
    pkt_byte_t   pkt_reg [PKT_DEPTH];
    pkt_t        pkt_eff;

    logic        accept;
    logic        is_start;
    logic        take;
    logic [3:0]  len;
    logic [3:0]  base_cnt;
    logic        wr_en;
    logic [3:0]  after_cnt;
    logic        emit;
    logic        prox;
    pen_event_t  evt;
    pen_event_t  out_evt;
    logic        room;

    assign accept   = s_tvalid & s_tready;
    assign s_tready = room;
    assign len      = tilt_mode_reg ? TILT_LEN : SHORT_LEN;
    assign is_start = s_tdata[START_BIT];

    // Packet framing: start byte restarts, stray bytes are dropped
    assign take      = accept & (is_start | (count_reg != 4'd0));
    assign base_cnt  = is_start ? 4'd0 : count_reg;
    assign wr_en     = take & (base_cnt < len);
    assign after_cnt = wr_en ? base_cnt + 4'd1 : base_cnt;
    assign emit      = take & (after_cnt == len);

    always_comb
    begin
        count_next = count_reg;
        if (take)
        begin
            count_next = emit ? 4'd0 : after_cnt;
        end
    end

    // Packet bytes with the incoming byte overlaid at its slot
    always_comb
    begin
        for (int i = 0; i < PKT_DEPTH; i++)
        begin
            pkt_eff[i] = (wr_en && base_cnt == 4'(i)) ? s_tdata[6:0] : pkt_reg[i];
        end
    end

    // Proximity tracking, eraser latched on entry
    assign prox = pkt_eff[0][PROX_BIT];

    always_comb
    begin
        in_prox_next = in_prox_reg;
        eraser_next  = eraser_reg;
        if (emit)
        begin
            if (!in_prox_reg && prox)
            begin
                in_prox_next = 1'b1;
                eraser_next  = pkt_eff[3][SIDE2_BIT];
            end
            else if (in_prox_reg && !prox)
            begin
                in_prox_next = 1'b0;
                eraser_next  = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_mode_reg <= 1'b0;
            count_reg     <= 4'd0;
            in_prox_reg   <= 1'b0;
            eraser_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tilt_mode_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            in_prox_reg <= in_prox_next;
            eraser_reg  <= eraser_next;
        end
    end

    // Packet byte store
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PKT_DEPTH; i++)
        begin
            if (wr_en && base_cnt == 4'(i))
            begin
                pkt_reg[i] <= s_tdata[6:0];
            end
        end
    end

    tpd_decode u_decode (
        .pkt     (pkt_eff),
        .tilt_on (tilt_mode_reg),
        .eraser  (eraser_next),
        .evt     (evt)
    );

    tpd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_evt  (evt),
        .room      (room),
        .out_valid (m_tvalid),
        .out_evt   (out_evt),
        .out_ready (m_tready)
    );

    assign m_tdata = {(EVT_BUS_W - EVT_W)'(0), out_evt};

endmodule

`default_nettype wire

### design/tpd_decode.sv
// Field extraction from a complete packet into one pen event.
`default_nettype none

module tpd_decode
    import tpd_pkg::*;
(
    input  pkt_t       pkt,
    input  logic       tilt_on,
    input  logic       eraser,
    output pen_event_t evt
);

    pkt_byte_t b0;
    pkt_byte_t b3;
    pkt_byte_t b6;

    assign b0 = pkt[0];
    assign b3 = pkt[3];
    assign b6 = pkt[6];

    // Assemble fields; side switches are masked while erasing
    always_comb
    begin
        evt.in_range = b0[PROX_BIT];
        evt.pos_x    = {b0[1:0], pkt[1], pkt[2]};
        evt.pos_y    = {b3[1:0], pkt[4], pkt[5]};
        evt.pressure = {~b6[PRESS_HI_N], b6[5:0], b3[PRESS0_BIT]};
        evt.is_puck  = ~b0[STYLUS_BIT];
        evt.eraser   = eraser;
        evt.side_one = ~eraser & b3[SIDE1_BIT];
        evt.side_two = ~eraser & b3[SIDE2_BIT];
        evt.tip      = b3[TIP_BIT];
        evt.tilt_x   = tilt_on ? pkt[7] : 7'sd0;
        evt.tilt_y   = tilt_on ? pkt[8] : 7'sd0;
    end

endmodule

`default_nettype wire

### design/tpd_skid.sv
// Two-entry output register with skid slot for decoded events.
`default_nettype none

module tpd_skid
    import tpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pen_event_t push_evt,
    output logic       room,
    output logic       out_valid,
    output pen_event_t out_evt,
    input  logic       out_ready
);

    logic       main_valid_reg;
    logic       skid_valid_reg;
    pen_event_t main_reg;
    pen_event_t skid_reg;
    logic       pop;

    assign pop       = main_valid_reg & out_ready;
    assign room      = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_evt   = main_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_reg <= push_evt;
            end
            else
            begin
                skid_reg <= push_evt;
            end
        end
    end

endmodule

`default_nettype wire

### bench/tablet_packet_decoder_checker.sv
// Checker for the tablet packet decoder: predicts pen events from the accepted bytes and compares.
module tablet_packet_decoder_checker
    import tpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    output int          failures,
    output int          outstanding,
    output int          events_checked,
    output int          bytes_taken
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the decoder state
    pkt_byte_t  pkt_mem [PKT_DEPTH];
    logic [3:0] fill;
    logic       near;
    logic       eraser_held;
    logic       tilt_on;

    pen_event_t expected_events [$];

    int fail_tally    = 0;
    int event_tally   = 0;
    int byte_tally    = 0;
    int pending_count = 0;

    assign failures       = fail_tally;
    assign events_checked = event_tally;
    assign bytes_taken    = byte_tally;
    assign outstanding    = pending_count;

    // Take one byte into the shadow state; returns 1 when it completes a packet
    function automatic bit decode_byte(input logic [7:0] rx, output pen_event_t ev);
        logic [3:0] plen;
        logic       prox;
        plen = tilt_on ? TILT_LEN : SHORT_LEN;
        ev   = '0;
        if (rx[START_BIT])
            fill = 4'd0;
        else if (fill == 4'd0)
            return 1'b0;
        if (fill < plen)
        begin
            pkt_mem[fill] = rx[6:0];
            fill = fill + 4'd1;
        end
        if (fill != plen)
            return 1'b0;
        fill = 4'd0;

        // Proximity session: eraser choice latched on entry only
        prox = pkt_mem[0][PROX_BIT];
        if (!near)
        begin
            if (prox)
            begin
                near        = 1'b1;
                eraser_held = pkt_mem[3][SIDE2_BIT];
            end
        end
        else if (!prox)
        begin
            near        = 1'b0;
            eraser_held = 1'b0;
        end

        ev.in_range = prox;
        ev.pos_x    = {pkt_mem[0][1:0], pkt_mem[1], pkt_mem[2]};
        ev.pos_y    = {pkt_mem[3][1:0], pkt_mem[4], pkt_mem[5]};
        ev.pressure = {~pkt_mem[6][PRESS_HI_N], pkt_mem[6][5:0], pkt_mem[3][PRESS0_BIT]};
        ev.is_puck  = ~pkt_mem[0][STYLUS_BIT];
        ev.eraser   = eraser_held;
        ev.side_one = eraser_held ? 1'b0 : pkt_mem[3][SIDE1_BIT];
        ev.side_two = eraser_held ? 1'b0 : pkt_mem[3][SIDE2_BIT];
        ev.tip      = pkt_mem[3][TIP_BIT];
        ev.tilt_x   = (plen == TILT_LEN) ? pkt_mem[7] : 7'sd0;
        ev.tilt_y   = (plen == TILT_LEN) ? pkt_mem[8] : 7'sd0;
        return 1'b1;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_tally++;
        end
    endtask

    // Watch both channels and the config port at each edge
    always @(posedge clk or negedge rst_n)
    begin
        pen_event_t ev;
        pen_event_t got;
        if (!rst_n)
        begin
            foreach (pkt_mem[i])
                pkt_mem[i] = '0;
            fill        = 4'd0;
            near        = 1'b0;
            eraser_held = 1'b0;
            tilt_on     = 1'b0;
            expected_events.delete();
            pending_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                tilt_on = cfg_wr_data;

            if (s_tvalid && s_tready)
            begin
                byte_tally++;
                if (decode_byte(s_tdata, ev))
                    expected_events.push_back(ev);
            end

            if (m_tvalid && m_tready)
            begin
                got = m_tdata[EVT_W-1:0];
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected event, expected none, actual %0h",
                             $time, m_tdata);
                    fail_tally++;
                end
                else
                begin
                    ev = expected_events.pop_front();
                    event_tally++;
                    compare_field("in_range", ev.in_range, got.in_range);
                    compare_field("pos_x",    ev.pos_x,    got.pos_x);
                    compare_field("pos_y",    ev.pos_y,    got.pos_y);
                    compare_field("pressure", ev.pressure, got.pressure);
                    compare_field("is_puck",  ev.is_puck,  got.is_puck);
                    compare_field("eraser",   ev.eraser,   got.eraser);
                    compare_field("side_one", ev.side_one, got.side_one);
                    compare_field("side_two", ev.side_two, got.side_two);
                    compare_field("tip",      ev.tip,      got.tip);
                    compare_field("tilt_x",   ev.tilt_x,   got.tilt_x);
                    compare_field("tilt_y",   ev.tilt_y,   got.tilt_y);
                    compare_field("pad",      '0,          m_tdata[63:EVT_W]);
                end
            end

            pending_count <= expected_events.size();
        end
    end

endmodule

### bench/tablet_packet_decoder_test.sv
// Top of the tablet packet decoder bench: clock, reset, byte stream, output stalls and verdict.
module tablet_packet_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tpd_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int SETTLE      = 4;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic [7:0]  s_tdata     = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;

    int failures;
    int outstanding;
    int events_checked;
    int bytes_taken;
    int cycle_count = 0;
    int holds_done  = 0;

    bit cur_tilt  = 1'b0;
    bit pen_near  = 1'b0;
    bit src_calm  = 1'b0;
    bit snk_calm  = 1'b0;
    bit hold_req  = 1'b0;

    // Opening stream for 7-byte mode: stray byte, all ones, aborted packet,
    // all zeros (leaves proximity), plain stylus entering proximity
    logic [7:0] short_opening [24] = '{
        8'h00,
        8'hFF, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F,
        8'hE3, 8'h55,
        8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hE1, 8'h0A, 8'h33, 8'h1C, 8'h44, 8'h66, 8'h15
    };

    // Tilt packet: switch bits while already in range, tilt at both extremes
    logic [7:0] tilt_opening [9] = '{
        8'hE0, 8'h01, 8'h02, 8'h3B, 8'h04, 8'h05, 8'h40, 8'h40, 8'h3F
    };

    tablet_packet_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    tablet_packet_decoder_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .failures       (failures),
        .outstanding    (outstanding),
        .events_checked (events_checked),
        .bytes_taken    (bytes_taken)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // Offer one byte and wait until it is taken
    task automatic send_byte(input logic [7:0] rx);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Start byte with a proximity bit that mostly stays put between packets
    function automatic logic [7:0] start_byte();
        if ($urandom_range(0, 6) == 0)
            pen_near = !pen_near;
        return {1'b1, pen_near, 6'($urandom_range(0, 63))};
    endfunction

    // Start byte followed by count-1 data bytes
    task automatic send_packet(input int count);
        send_byte(start_byte());
        for (int i = 1; i < count; i++)
            send_byte(8'($urandom_range(0, 127)));
    endtask

    // Stop offering and wait until every expected event has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_tilt(input bit on);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_tilt = on;
    endtask

    // Mostly whole packets, some cut short, some stray data bytes
    task automatic run_random(input int n_items);
        int made;
        int plen;
        int pick;
        int cut;
        made = 0;
        while (made < n_items)
        begin
            plen = cur_tilt ? TILT_LEN : SHORT_LEN;
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 7) == 0)
                src_calm = !src_calm;
            if (pick < 78)
            begin
                send_packet(plen);
                made += plen;
            end
            else if (pick < 90)
            begin
                cut = $urandom_range(1, plen - 1);
                send_packet(cut);
                made += cut;
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 127)));
            end
        end
    endtask

    // Output side: random stall per event, long hold-off on request
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            if ($urandom_range(0, 9) == 0)
                snk_calm = !snk_calm;
            stall = pick_gap(snk_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Stimulus
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 7-byte mode, directed
        set_tilt(1'b0);
        foreach (short_opening[i])
            send_byte(short_opening[i]);
        drain();

        // Tilt mode, directed then random with a long output hold-off
        set_tilt(1'b1);
        foreach (tilt_opening[i])
            send_byte(tilt_opening[i]);
        run_random(150);
        src_calm = 1'b1;
        hold_req = 1'b1;
        repeat (4) send_packet(TILT_LEN);
        run_random(150);

        // Leave 7 bytes of a tilt packet, then drop to 7-byte mode
        send_packet(7);
        drain();
        set_tilt(1'b0);
        repeat (2) send_byte(8'($urandom_range(0, 127)));
        run_random(150);

        // Sender pause until every event is out
        drain();
        run_random(150);

        // Start a short packet, then switch to tilt mid-packet
        send_packet(3);
        drain();
        set_tilt(1'b1);
        for (int i = 3; i < TILT_LEN; i++)
            send_byte(8'($urandom_range(0, 127)));
        run_random(200);

        // Leave 8 bytes of a tilt packet, then drop to 7-byte mode
        send_packet(8);
        drain();
        set_tilt(1'b0);
        repeat (2) send_byte(8'($urandom_range(0, 127)));
        run_random(200);

        drain();
        repeat (10) @(posedge clk);

        $display("Run covered %0d bytes and %0d pen events in both packet lengths,",
                 bytes_taken, events_checked);
        $display("with mid-packet mode switches and %0d long output hold-off(s).", holds_done);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
